FILE: hw/rtl/itaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared types, character codes and sizes for the formatter modules.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int unsigned OPERAND_W         = 64;
    localparam int unsigned HALF_W            = 32;
    localparam int unsigned FIELD_W           = 7;
    localparam int unsigned CHAR_W            = 8;
    localparam int unsigned MAX_WIDTH_DEFAULT = 64;
    localparam int unsigned DIGITS            = 20;
    localparam int unsigned DIGIT_W           = 4;
    localparam int unsigned DIGIT_IDX_W       = 5;
    localparam int unsigned DEC_W             = DIGITS * DIGIT_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_LHEX = 2'd2,
        MODE_UHEX = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MEASURE,
        ST_PAD,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

    typedef struct packed {
        logic [OPERAND_W-1:0] mag;
        logic                 wide;
        logic                 is_hex;
        logic                 upper;
        logic                 has_sign;
        logic [CHAR_W-1:0]    sign_char;
        logic [CHAR_W-1:0]    pad_char;
        logic [FIELD_W-1:0]   width;
    } job_t;

endpackage

FILE: hw/rtl/itaf_num_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number channel
// Carries one integer and its conversion request per transfer.
// ----------------------------------------------------------------------------
interface itaf_num_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  mode;
    logic        wide_operand;
    logic [6:0]  field_width;
    logic        zero_pad;
    logic        print_sign;

    modport source (
        output valid, value, mode, wide_operand, field_width, zero_pad, print_sign,
        input  ready
    );
    modport sink (
        input  valid, value, mode, wide_operand, field_width, zero_pad, print_sign,
        output ready
    );
endinterface

FILE: hw/rtl/itaf_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Carries one ASCII character and an end-of-number flag per transfer.
// ----------------------------------------------------------------------------
interface itaf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (
        output valid, out_char, last_char,
        input  ready
    );
    modport sink (
        input  valid, out_char, last_char,
        output ready
    );
endinterface

FILE: hw/rtl/itaf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts numbers, works out magnitude, sign and padding, and queues the jobs.
// ----------------------------------------------------------------------------
module itaf_front #(
    parameter int unsigned MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    itaf_num_if.sink            number,
    output itaf_pkg::job_t      job,
    output logic                job_valid,
    input  logic                job_ready
);
    import itaf_pkg::*;

    localparam int unsigned DEPTH = 2;

    job_t                      queue_reg [DEPTH];
    logic                      wr_ptr_reg;
    logic                      wr_ptr_next;
    logic                      rd_ptr_reg;
    logic                      rd_ptr_next;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    logic                      push;
    logic                      pop;
    job_t                      job_in;
    mode_t                     mode;
    logic [OPERAND_W-1:0]      operand;
    logic [OPERAND_W-1:0]      negated;
    logic                      top_bit;
    logic                      neg;

    always_comb
    begin
        mode    = mode_t'(number.mode);
        operand = number.wide_operand ? number.value
                                      : {{HALF_W{1'b0}}, number.value[HALF_W-1:0]};
        top_bit = number.wide_operand ? number.value[OPERAND_W-1] : number.value[HALF_W-1];
        neg     = (mode == MODE_SDEC) && top_bit;
        negated = {OPERAND_W{1'b0}} - operand;
        if (!number.wide_operand)
        begin
            negated[OPERAND_W-1:HALF_W] = '0;
        end

        job_in.mag       = neg ? negated : operand;
        job_in.wide      = number.wide_operand;
        job_in.is_hex    = (mode == MODE_LHEX) || (mode == MODE_UHEX);
        job_in.upper     = (mode == MODE_UHEX);
        job_in.has_sign  = !job_in.is_hex && (neg || number.print_sign);
        job_in.sign_char = neg ? CHAR_MINUS : CHAR_PLUS;
        job_in.pad_char  = number.zero_pad ? CHAR_ZERO : CHAR_SPACE;
        job_in.width     = (number.field_width > FIELD_W'(MAX_WIDTH)) ? FIELD_W'(MAX_WIDTH)
                                                                      : number.field_width;
    end

    assign number.ready = (count_reg != 2'(DEPTH));
    assign push         = number.valid && number.ready;
    assign job_valid    = (count_reg != 2'd0);
    assign pop          = job_valid && job_ready;
    assign job          = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: hw/rtl/itaf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter back end
// Converts a queued job to digits and streams pad, sign and digit characters.
// ----------------------------------------------------------------------------
module itaf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  itaf_pkg::job_t      job,
    input  logic                job_valid,
    output logic                job_ready,
    itaf_char_if.source         text
);
    import itaf_pkg::*;

    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned ITER_W        = 4;
    localparam int unsigned WORK_W        = DEC_W + OPERAND_W;
    localparam logic [ITER_W-1:0] LAST_ITER_WIDE = ITER_W'(OPERAND_W / BITS_PER_STEP - 1);
    localparam logic [ITER_W-1:0] LAST_ITER_HALF = ITER_W'(HALF_W / BITS_PER_STEP - 1);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CHAR_W-1:0]        out_char_reg;
    logic [CHAR_W-1:0]        out_char_next;
    logic                     last_reg;
    logic                     last_next;
    logic [OPERAND_W-1:0]     bin_reg;
    logic [OPERAND_W-1:0]     bin_next;
    logic [DEC_W-1:0]         dec_reg;
    logic [DEC_W-1:0]         dec_next;
    logic [ITER_W-1:0]        iter_reg;
    logic [ITER_W-1:0]        iter_next;
    logic [DIGIT_IDX_W-1:0]   ndig_reg;
    logic [DIGIT_IDX_W-1:0]   ndig_next;
    logic [DIGIT_IDX_W-1:0]   idx_reg;
    logic [DIGIT_IDX_W-1:0]   idx_next;
    logic [FIELD_W-1:0]       pad_cnt_reg;
    logic [FIELD_W-1:0]       pad_cnt_next;
    logic                     has_sign_reg;
    logic                     upper_reg;
    logic [CHAR_W-1:0]        sign_char_reg;
    logic [CHAR_W-1:0]        pad_char_reg;
    logic [FIELD_W-1:0]       width_reg;
    logic                     out_load;
    logic [FIELD_W-1:0]       str_len;
    logic [DIGIT_IDX_W-1:0]   msd;

    function automatic logic [WORK_W-1:0] dabble_step(logic [WORK_W-1:0] x);
        logic [WORK_W-1:0] t;
        int                s;
        int                d;
        t = x;
        for (s = 0; s < BITS_PER_STEP; s++)
        begin
            for (d = 0; d < DIGITS; d++)
            begin
                if (t[OPERAND_W + d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    t[OPERAND_W + d*DIGIT_W +: DIGIT_W] =
                        t[OPERAND_W + d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            t = {t[WORK_W-2:0], 1'b0};
        end
        return t;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

    always_comb
    begin
        msd = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (dec_reg[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                msd = DIGIT_IDX_W'(d);
            end
        end
    end

    assign str_len   = FIELD_W'(msd) + FIELD_W'(1) + FIELD_W'(has_sign_reg);
    assign out_load  = !out_valid_reg || text.ready;
    assign job_ready = (state_reg == ST_IDLE);

    assign text.valid     = out_valid_reg;
    assign text.out_char  = out_char_reg;
    assign text.last_char = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        bin_next       = bin_reg;
        dec_next       = dec_reg;
        iter_next      = iter_reg;
        ndig_next      = ndig_reg;
        idx_next       = idx_reg;
        pad_cnt_next   = pad_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    bin_next  = job.wide ? job.mag : {job.mag[HALF_W-1:0], {HALF_W{1'b0}}};
                    dec_next  = job.is_hex ? {{(DEC_W - OPERAND_W){1'b0}}, job.mag} : '0;
                    iter_next = job.wide ? LAST_ITER_WIDE : LAST_ITER_HALF;
                    state_next = job.is_hex ? ST_MEASURE : ST_CONV;
                end
            end
            ST_CONV:
            begin
                {dec_next, bin_next} = dabble_step({dec_reg, bin_reg});
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = ST_MEASURE;
                end
            end
            ST_MEASURE:
            begin
                ndig_next    = msd + 1'b1;
                idx_next     = msd;
                pad_cnt_next = (width_reg > str_len) ? (width_reg - str_len) : '0;
                if (width_reg > str_len)
                begin
                    state_next = ST_PAD;
                end
                else if (has_sign_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_PAD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pad_char_reg;
                    last_next      = 1'b0;
                    pad_cnt_next   = pad_cnt_reg - 1'b1;
                    if (pad_cnt_reg == FIELD_W'(1))
                    begin
                        state_next = has_sign_reg ? ST_SIGN : ST_DIGIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sign_char_reg;
                    last_next      = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(dec_reg[idx_reg*DIGIT_W +: DIGIT_W], upper_reg);
                    last_next      = (idx_reg == '0);
                    idx_next       = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        bin_reg      <= bin_next;
        dec_reg      <= dec_next;
        iter_reg     <= iter_next;
        ndig_reg     <= ndig_next;
        idx_reg      <= idx_next;
        pad_cnt_reg  <= pad_cnt_next;
        if (state_reg == ST_IDLE && job_valid)
        begin
            has_sign_reg  <= job.has_sign;
            upper_reg     <= job.upper;
            sign_char_reg <= job.sign_char;
            pad_char_reg  <= job.pad_char;
            width_reg     <= job.width;
        end
    end

    // The digit pointer never runs above the most significant digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (idx_reg < ndig_reg))
        else $error("digit pointer beyond digit count");

    // Padding is only entered with characters left to pad.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (pad_cnt_reg != '0))
        else $error("pad state with empty pad count");

    // A sign character is only emitted for jobs that carry one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> has_sign_reg)
        else $error("sign state without a sign");

    // The final digit of a number is followed by a return to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && out_load && idx_reg == '0) |=> (state_reg == ST_IDLE && last_reg))
        else $error("last digit did not close the number");

endmodule

FILE: hw/rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Formats 32- or 64-bit integers as decimal or hex text.
// ----------------------------------------------------------------------------
// Usage: each transfer on the number channel carries an operand and its
// conversion request. The text channel returns the formatted characters, most
// significant first, with last_char set on the final character of a number.
// A two-entry job queue sits between the front end and the converter, so new
// numbers are taken while earlier ones are still being printed.
// Per number, the back end takes the job, converts a decimal operand with the
// four-bit-per-cycle binary-to-BCD converter (no conversion for hex), counts
// the digits, then emits pad, sign and digit characters through the single
// character output register, one character a cycle while the receiver is ready.
// The first character follows the job queue, the conversion and the digit count.
// Reset empties the queue and drops any character in flight. When
// the receiver stalls, the current character holds in the output register, the
// back end waits, and the queue fills until the number channel drops ready.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
    parameter int unsigned MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    itaf_num_if.sink     number,
    itaf_char_if.source  text
);
    import itaf_pkg::*;

    job_t job;
    logic job_valid;
    logic job_ready;

    itaf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    itaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .text      (text)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Sends numbers with decimal and hex conversion requests through the number
// channel and checks every returned character and end-of-number flag against
// a formatter model that the testbench keeps itself. A directed set covers
// the edge cases, then random numbers run through four idling phases.
// ----------------------------------------------------------------------------
module tb_top;

    import itaf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned RANDOM_PER_PHASE = 80;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [63:0] value;
        mode_t       mode;
        logic        wide;
        logic [6:0]  field_width;
        logic        zero_pad;
        logic        print_sign;
    } number_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic clk;
    logic rst_n;

    itaf_num_if  number_ch ();
    itaf_char_if text_ch ();

    integer_to_ascii_formatter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .number(number_ch),
        .text  (text_ch)
    );

    number_req_t pending_numbers[$];
    text_char_t  expected_text[$];
    number_req_t number_on_bus;
    text_char_t  oldest_char;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned numbers_sent;
    int unsigned chars_checked;
    int unsigned mismatches;
    int unsigned cycles;

    // Expands one request into the characters the formatter must emit.
    function automatic void predict_characters(number_req_t req);
        logic [63:0] v;
        logic [63:0] mag;
        logic [3:0]  nib;
        logic [7:0]  alpha;
        logic [7:0]  pad_char;
        logic [7:0]  digits[$];
        int unsigned width;
        int unsigned pads;
        text_char_t  c;

        v = req.wide ? req.value : {32'd0, req.value[31:0]};
        width = (req.field_width > 7'd64) ? 64 : 32'(req.field_width);
        pad_char = req.zero_pad ? CHAR_ZERO : CHAR_SPACE;
        if (req.mode == MODE_UDEC || req.mode == MODE_SDEC)
        begin
            mag = v;
            if (req.mode == MODE_SDEC && (req.wide ? v[63] : v[31]))
            begin
                mag = 64'd0 - v;
                if (!req.wide)
                    mag = {32'd0, mag[31:0]};
            end
            do
            begin
                digits.push_back(CHAR_ZERO + 8'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (req.mode == MODE_SDEC && (req.wide ? v[63] : v[31]))
                digits.push_back(CHAR_MINUS);
            else if (req.print_sign)
                digits.push_back(CHAR_PLUS);
        end
        else
        begin
            alpha = (req.mode == MODE_UHEX) ? CHAR_UPPER_A : CHAR_LOWER_A;
            do
            begin
                nib = v[3:0];
                digits.push_back((nib < 10) ? CHAR_ZERO + 8'(nib) : alpha + 8'(nib - 10));
                v = v >> 4;
            end while (v != 0);
        end
        pads = (width > digits.size()) ? width - digits.size() : 0;
        c.last = 1'b0;
        repeat (pads)
        begin
            c.ch = pad_char;
            expected_text.push_back(c);
        end
        while (digits.size() > 0)
        begin
            c.ch = digits.pop_back();
            c.last = (digits.size() == 0);
            expected_text.push_back(c);
        end
    endfunction

    task automatic queue_number(logic [63:0] value, mode_t mode, logic wide,
                                logic [6:0] field_width, logic zero_pad, logic print_sign);
        number_req_t req;

        req.value = value;
        req.mode = mode;
        req.wide = wide;
        req.field_width = field_width;
        req.zero_pad = zero_pad;
        req.print_sign = print_sign;
        pending_numbers.push_back(req);
    endtask

    task automatic queue_random_number();
        logic [63:0] value;
        logic [63:0] power;
        logic [6:0]  fw;
        int unsigned pick;

        pick = $urandom_range(9);
        case (pick)
            0: value = 64'($urandom_range(999));
            1, 2: value = {$urandom, $urandom};
            3: value = {32'd0, $urandom};
            4:
            begin
                power = 1;
                repeat ($urandom_range(19, 1))
                    power = power * 10;
                value = power - 64'($urandom_range(1));
            end
            5: value = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(999));
            6: value = {32'd0, 32'hFFFF_FFFF - 32'($urandom_range(999))};
            7: value = {$urandom, 32'h8000_0000 + 32'($urandom_range(3))};
            8: value = {32'h8000_0000 + 32'($urandom_range(3)), $urandom};
            default: value = 64'd0;
        endcase
        pick = $urandom_range(9);
        if (pick < 7)
            fw = 7'($urandom_range(24));
        else if (pick < 9)
            fw = 7'($urandom_range(64, 25));
        else
            fw = 7'($urandom_range(127, 65));
        queue_number(value, mode_t'($urandom_range(3)), 1'($urandom_range(1)), fw,
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_numbers.size() != 0 || number_ch.valid || expected_text.size() != 0);
    endtask

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE)
            queue_random_number();
        wait_until_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Number driver: a request is predicted at the edge where its transfer happens.
    always @(posedge clk)
    begin
        if (!rst_n)
            number_ch.valid <= 1'b0;
        else
        begin
            if (number_ch.valid && number_ch.ready)
            begin
                predict_characters(number_on_bus);
                numbers_sent++;
            end
            if (!number_ch.valid || number_ch.ready)
            begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    number_on_bus = pending_numbers.pop_front();
                    number_ch.valid        <= 1'b1;
                    number_ch.value        <= number_on_bus.value;
                    number_ch.mode         <= number_on_bus.mode;
                    number_ch.wide_operand <= number_on_bus.wide;
                    number_ch.field_width  <= number_on_bus.field_width;
                    number_ch.zero_pad     <= number_on_bus.zero_pad;
                    number_ch.print_sign   <= number_on_bus.print_sign;
                end
                else
                    number_ch.valid <= 1'b0;
            end
        end
    end

    // Character monitor and receiver stall control.
    always @(posedge clk)
    begin
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character transfer: out_char=%h last_char=%b",
                           text_ch.out_char, text_ch.last_char);
                    mismatches++;
                end
                else
                begin
                    oldest_char = expected_text.pop_front();
                    chars_checked++;
                    if (text_ch.out_char !== oldest_char.ch)
                    begin
                        $error("out_char mismatch: expected %h, actual %h",
                               oldest_char.ch, text_ch.out_char);
                        mismatches++;
                    end
                    if (text_ch.last_char !== oldest_char.last)
                    begin
                        $error("last_char mismatch: expected %b, actual %b",
                               oldest_char.last, text_ch.last_char);
                        mismatches++;
                    end
                end
            end
            text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d characters outstanding.",
                     expected_text.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.value = 64'd0;
        number_ch.mode = MODE_UDEC;
        number_ch.wide_operand = 1'b0;
        number_ch.field_width = 7'd0;
        number_ch.zero_pad = 1'b0;
        number_ch.print_sign = 1'b0;
        text_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        numbers_sent = 0;
        chars_checked = 0;
        mismatches = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_number(64'd0, MODE_UDEC, 1'b0, 7'd0, 1'b0, 1'b0);
        queue_number(64'h0000_0000_FFFF_FFFF, MODE_UDEC, 1'b0, 7'd0, 1'b0, 1'b0);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC, 1'b1, 7'd0, 1'b0, 1'b1);
        queue_number(64'h0000_0000_8000_0000, MODE_SDEC, 1'b0, 7'd0, 1'b0, 1'b0);
        queue_number(64'h8000_0000_0000_0000, MODE_SDEC, 1'b1, 7'd22, 1'b0, 1'b1);
        queue_number(64'h0000_0000_FFFF_FFFF, MODE_SDEC, 1'b0, 7'd6, 1'b1, 1'b0);
        queue_number(64'd12, MODE_SDEC, 1'b0, 7'd5, 1'b1, 1'b1);
        queue_number(64'hDEAD_BEEF, MODE_LHEX, 1'b0, 7'd0, 1'b0, 1'b1);
        queue_number(64'hFEDC_BA98_7654_3210, MODE_UHEX, 1'b1, 7'd20, 1'b0, 1'b0);
        queue_number(64'd0, MODE_LHEX, 1'b1, 7'd0, 1'b1, 1'b1);
        queue_number(64'd7, MODE_UDEC, 1'b0, 7'd127, 1'b0, 1'b0);
        queue_number(64'd7, MODE_UDEC, 1'b1, 7'd64, 1'b1, 1'b0);
        queue_number(64'd7, MODE_SDEC, 1'b0, 7'd65, 1'b0, 1'b1);
        queue_number(64'h1234_5678_9ABC_DEF0, MODE_LHEX, 1'b0, 7'd3, 1'b0, 1'b0);
        queue_number(64'h0000_0000_7FFF_FFFF, MODE_SDEC, 1'b0, 7'd0, 1'b0, 1'b0);
        queue_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC, 1'b1, 7'd0, 1'b0, 1'b1);
        queue_number(64'hFFFF_FFFF_0000_0005, MODE_UDEC, 1'b0, 7'd2, 1'b1, 1'b0);
        queue_number(64'd0, MODE_SDEC, 1'b1, 7'd3, 1'b1, 1'b1);
        queue_number(64'd42, MODE_UDEC, 1'b0, 7'd0, 1'b0, 1'b1);
        queue_number(64'h00AB_CDEF, MODE_UHEX, 1'b0, 7'd1, 1'b0, 1'b1);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UHEX, 1'b1, 7'd16, 1'b1, 1'b0);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_LHEX, 1'b0, 7'd85, 1'b0, 1'b0);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC, 1'b1, 7'd42, 1'b1, 1'b1);
        wait_until_drained();

        run_random_phase(0, 0);
        run_random_phase(78, 0);
        run_random_phase(0, 78);
        run_random_phase(9, 9);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Formatted %0d numbers into %0d checked characters over four idling phases.",
                 numbers_sent, chars_checked);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/itaf_pkg.sv
hw/rtl/itaf_num_if.sv
hw/rtl/itaf_char_if.sv
hw/rtl/itaf_front.sv
hw/rtl/itaf_back.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/tb_top.sv
